### design/hvt_pkg.sv
// Shared constants and register indexes for the homogeneous vertex transform.
package hvt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ELEM_W          = 32;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 4'd0,
        REG_ROW0_COLS23 = 4'd1,
        REG_ROW1_COLS01 = 4'd2,
        REG_ROW1_COLS23 = 4'd3,
        REG_ROW2_COLS01 = 4'd4,
        REG_ROW2_COLS23 = 4'd5,
        REG_ROW3_COLS01 = 4'd6,
        REG_ROW3_COLS23 = 4'd7
    } reg_idx_t;

endpackage

### design/hvt_mac.sv
// Front end: matrix products, column sums and divider setup for the three coordinates.
module hvt_mac #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF,
    parameter int AW          = COORD_WIDTH + hvt_pkg::ELEM_W + FRAC_BITS + 2,
    parameter int RW          = AW + FRAC_BITS + COORD_WIDTH
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic [hvt_pkg::NUM_REGS-1:0][hvt_pkg::CFG_DATA_W-1:0] cfg_regs,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic [2:0][COORD_WIDTH-1:0]                       in_pt,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [2:0][RW-1:0]                                out_r,
    output logic [2:0]                                        out_neg,
    output logic [2:0]                                        out_ovf,
    output logic [2:0][COORD_WIDTH-1:0]                       out_uval,
    output logic [2:0]                                        out_usat,
    output logic [AW-1:0]                                     out_d,
    output logic                                              out_wz
);

    localparam int PW = COORD_WIDTH + hvt_pkg::ELEM_W;
    localparam int EW = hvt_pkg::ELEM_W;
    localparam int W  = COORD_WIDTH;

    logic                          va_reg;
    logic                          vb_reg;
    logic                          ready_a;
    logic                          ready_b;
    logic signed [PW-1:0]          prod_reg [3][4];
    logic signed [EW-1:0]          trans_reg [4];
    logic signed [PW-1:0]          prod_next [3][4];
    logic signed [AW-1:0]          acc [4];
    logic [AW-1:0]                 abs_w;
    logic [2:0][RW-1:0]            r_next;
    logic [2:0]                    neg_next;
    logic [2:0]                    ovf_next;
    logic [2:0][W-1:0]             uval_next;
    logic [2:0]                    usat_next;
    logic [2:0][RW-1:0]            r_reg;
    logic [2:0]                    neg_reg;
    logic [2:0]                    ovf_reg;
    logic [2:0][W-1:0]             uval_reg;
    logic [2:0]                    usat_reg;
    logic [AW-1:0]                 d_reg;
    logic                          wz_reg;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                prod_next[r][c] = $signed(in_pt[r]) *
                    $signed(cfg_regs[r*2 + c/2][(c%2)*EW +: EW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ready_a) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_a) begin
            for (int c = 0; c < 4; c++) begin
                trans_reg[c] <= $signed(
                    cfg_regs[int'(hvt_pkg::REG_ROW3_COLS01) + c/2][(c%2)*EW +: EW]);
                for (int r = 0; r < 3; r++) begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
            end
        end
    end

    always_comb begin
        logic signed [AW-1:0] sh;
        logic signed [AW-1:0] maxv;
        logic [AW-1:0]        abs_v;
        maxv = $signed({{(AW-W+1){1'b0}}, {(W-1){1'b1}}});
        for (int c = 0; c < 4; c++) begin
            acc[c] = (AW'(trans_reg[c]) <<< FRAC_BITS) + AW'(prod_reg[0][c]) +
                     AW'(prod_reg[1][c]) + AW'(prod_reg[2][c]);
        end
        abs_w = acc[3][AW-1] ? AW'(-acc[3]) : AW'(acc[3]);
        for (int c = 0; c < 3; c++) begin
            sh = acc[c] >>> FRAC_BITS;
            if (sh > maxv) begin
                uval_next[c] = W'(maxv);
                usat_next[c] = 1'b1;
            end else if (sh < ~maxv) begin
                uval_next[c] = W'(~maxv);
                usat_next[c] = 1'b1;
            end else begin
                uval_next[c] = W'(sh);
                usat_next[c] = 1'b0;
            end
            abs_v        = acc[c][AW-1] ? AW'(-acc[c]) : AW'(acc[c]);
            r_next[c]    = RW'(abs_v) << FRAC_BITS;
            neg_next[c]  = acc[c][AW-1] ^ acc[3][AW-1];
            ovf_next[c]  = r_next[c] >= (RW'(abs_w) << W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ready_b) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (va_reg && ready_b) begin
            r_reg    <= r_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
            uval_reg <= uval_next;
            usat_reg <= usat_next;
            d_reg    <= abs_w;
            wz_reg   <= (acc[3] == '0);
        end
    end

    assign out_valid = vb_reg;
    assign out_r     = r_reg;
    assign out_neg   = neg_reg;
    assign out_ovf   = ovf_reg;
    assign out_uval  = uval_reg;
    assign out_usat  = usat_reg;
    assign out_d     = d_reg;
    assign out_wz    = wz_reg;

endmodule

### design/hvt_div_cell.sv
// One restoring divider cell that settles one quotient bit for all three coordinates.
module hvt_div_cell #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int AW          = 82,
    parameter int RW          = 130,
    parameter int BIT         = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0][RW-1:0]           in_r,
    input  logic [2:0][COORD_WIDTH-1:0]  in_q,
    input  logic [2:0]                   in_neg,
    input  logic [2:0]                   in_ovf,
    input  logic [2:0][COORD_WIDTH-1:0]  in_uval,
    input  logic [2:0]                   in_usat,
    input  logic [AW-1:0]                in_d,
    input  logic                         in_wz,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][RW-1:0]           out_r,
    output logic [2:0][COORD_WIDTH-1:0]  out_q,
    output logic [2:0]                   out_neg,
    output logic [2:0]                   out_ovf,
    output logic [2:0][COORD_WIDTH-1:0]  out_uval,
    output logic [2:0]                   out_usat,
    output logic [AW-1:0]                out_d,
    output logic                         out_wz
);

    logic                        valid_reg;
    logic                        ready;
    logic [RW-1:0]               dsh;
    logic [2:0][RW-1:0]          r_next;
    logic [2:0][COORD_WIDTH-1:0] q_next;
    logic [2:0][RW-1:0]          r_reg;
    logic [2:0][COORD_WIDTH-1:0] q_reg;
    logic [2:0]                  neg_reg;
    logic [2:0]                  ovf_reg;
    logic [2:0][COORD_WIDTH-1:0] uval_reg;
    logic [2:0]                  usat_reg;
    logic [AW-1:0]               d_reg;
    logic                        wz_reg;

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;
    assign dsh      = RW'(in_d) << BIT;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_next[c] = in_r[c];
            q_next[c] = in_q[c];
            if (in_r[c] >= dsh) begin
                r_next[c]      = in_r[c] - dsh;
                q_next[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready) begin
            r_reg    <= r_next;
            q_reg    <= q_next;
            neg_reg  <= in_neg;
            ovf_reg  <= in_ovf;
            uval_reg <= in_uval;
            usat_reg <= in_usat;
            d_reg    <= in_d;
            wz_reg   <= in_wz;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_neg   = neg_reg;
    assign out_ovf   = ovf_reg;
    assign out_uval  = uval_reg;
    assign out_usat  = usat_reg;
    assign out_d     = d_reg;
    assign out_wz    = wz_reg;

endmodule

### design/hvt_finish.sv
// Output stage: quotient sign, clamping, flags and the result register.
module hvt_finish #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0][COORD_WIDTH-1:0]  in_q,
    input  logic [2:0]                   in_neg,
    input  logic [2:0]                   in_ovf,
    input  logic [2:0][COORD_WIDTH-1:0]  in_uval,
    input  logic [2:0]                   in_usat,
    input  logic                         in_wz,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][COORD_WIDTH-1:0]  out_pt,
    output logic                         out_wz,
    output logic                         out_sat
);

    localparam int W = COORD_WIDTH;

    logic                valid_reg;
    logic                ready;
    logic [2:0][W-1:0]   pt_next;
    logic                sat_next;
    logic [2:0][W-1:0]   pt_reg;
    logic                wz_reg;
    logic                sat_reg;

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;

    always_comb begin
        logic [W-1:0] maxv;
        logic [W-1:0] minv;
        logic [W-1:0] negq;
        maxv     = {1'b0, {(W-1){1'b1}}};
        minv     = {1'b1, {(W-1){1'b0}}};
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++) begin
            negq = -in_q[c];
            if (in_wz) begin
                pt_next[c] = in_uval[c];
                sat_next   = sat_next | in_usat[c];
            end else if (in_ovf[c]) begin
                pt_next[c] = in_neg[c] ? minv : maxv;
                sat_next   = 1'b1;
            end else if (!in_neg[c]) begin
                pt_next[c] = in_q[c][W-1] ? maxv : in_q[c];
                sat_next   = sat_next | in_q[c][W-1];
            end else if (in_q[c] > minv) begin
                pt_next[c] = minv;
                sat_next   = 1'b1;
            end else begin
                pt_next[c] = negq;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready) begin
            pt_reg  <= pt_next;
            wz_reg  <= in_wz;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pt    = pt_reg;
    assign out_wz    = wz_reg;
    assign out_sat   = sat_reg;

endmodule

### design/homogeneous_vertex_transform.sv
// Throughput: one point per cycle while the output is not stalled.
// Each of the COORD_WIDTH divider cells settles one quotient bit.
// Every stage holds its beat under backpressure and empty stages keep taking new points.
// Reset (aresetn low, synchronous) clears all stage valids and sets the matrix registers to zero.
// Configuration writes are accepted in every cycle.
module homogeneous_vertex_transform #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hvt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_x, in_y, in_z from the lowest bit up, zero padded to whole bytes.
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, out_z from the lowest bit up, zero padded to whole bytes.
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // w_was_zero, saturated from the lowest bit up.
    output logic [1:0]                          m_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int AW  = COORD_WIDTH + hvt_pkg::ELEM_W + FRAC_BITS + 2;
    localparam int RW  = AW + FRAC_BITS + COORD_WIDTH;
    localparam int TDW = ((3*COORD_WIDTH+7)/8)*8;

    logic [hvt_pkg::NUM_REGS-1:0][hvt_pkg::CFG_DATA_W-1:0] cfg_reg;
    logic [2:0][W-1:0] in_pt;
    logic [2:0][W-1:0] out_pt;
    logic              out_wz;
    logic              out_sat;

    logic              c_valid [0:W];
    logic              c_ready [0:W];
    logic [2:0][RW-1:0] c_r    [0:W];
    logic [2:0][W-1:0]  c_q    [0:W];
    logic [2:0]         c_neg  [0:W];
    logic [2:0]         c_ovf  [0:W];
    logic [2:0][W-1:0]  c_uval [0:W];
    logic [2:0]         c_usat [0:W];
    logic [AW-1:0]      c_d    [0:W];
    logic               c_wz   [0:W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::NUM_REGS)) begin
            cfg_reg[cfg_index[hvt_pkg::REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    assign in_pt[0] = s_tdata[W-1:0];
    assign in_pt[1] = s_tdata[2*W-1:W];
    assign in_pt[2] = s_tdata[3*W-1:2*W];

    hvt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .AW          (AW),
        .RW          (RW)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_regs  (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pt     (in_pt),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_r     (c_r[0]),
        .out_neg   (c_neg[0]),
        .out_ovf   (c_ovf[0]),
        .out_uval  (c_uval[0]),
        .out_usat  (c_usat[0]),
        .out_d     (c_d[0]),
        .out_wz    (c_wz[0])
    );

    assign c_q[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        hvt_div_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .AW          (AW),
            .RW          (RW),
            .BIT         (W - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_r      (c_r[k]),
            .in_q      (c_q[k]),
            .in_neg    (c_neg[k]),
            .in_ovf    (c_ovf[k]),
            .in_uval   (c_uval[k]),
            .in_usat   (c_usat[k]),
            .in_d      (c_d[k]),
            .in_wz     (c_wz[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_r     (c_r[k+1]),
            .out_q     (c_q[k+1]),
            .out_neg   (c_neg[k+1]),
            .out_ovf   (c_ovf[k+1]),
            .out_uval  (c_uval[k+1]),
            .out_usat  (c_usat[k+1]),
            .out_d     (c_d[k+1]),
            .out_wz    (c_wz[k+1])
        );
    end

    hvt_finish #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid[W]),
        .in_ready  (c_ready[W]),
        .in_q      (c_q[W]),
        .in_neg    (c_neg[W]),
        .in_ovf    (c_ovf[W]),
        .in_uval   (c_uval[W]),
        .in_usat   (c_usat[W]),
        .in_wz     (c_wz[W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pt    (out_pt),
        .out_wz    (out_wz),
        .out_sat   (out_sat)
    );

    assign m_tdata = TDW'(out_pt);
    assign m_tuser = {out_sat, out_wz};

endmodule

### verif/tb_homogeneous_vertex_transform.sv
// Self-checking testbench for the homogeneous vertex transform with perspective divide.
module tb_homogeneous_vertex_transform;

    localparam int CW = hvt_pkg::COORD_WIDTH_DEF;
    localparam int FB = hvt_pkg::FRAC_BITS_DEF;
    localparam int DW = ((3 * CW + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = CW + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [hvt_pkg::CFG_IDX_W-1:0] UNUSED_IDX = 4'd11;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic                 w_zero, sat;
    } vertex_t;

    class vertex_scoreboard;
        logic signed [31:0] mat[4][4] = '{default: '0};
        vertex_t            pending[$];
        int                 errors;

        function void load_reg(int idx, logic [63:0] v);
            if (idx < hvt_pkg::NUM_REGS) begin
                mat[idx / 2][(idx % 2) * 2]     = v[31:0];
                mat[idx / 2][(idx % 2) * 2 + 1] = v[63:32];
            end
        endfunction

        function logic signed [CW-1:0] clamp(logic signed [127:0] v, inout logic sat);
            logic signed [127:0] hi_lim, lo_lim;
            hi_lim = (128'sd1 <<< (CW - 1)) - 1;
            lo_lim = -(128'sd1 <<< (CW - 1));
            if (v > hi_lim) begin
                sat = 1'b1;
                return hi_lim[CW-1:0];
            end
            if (v < lo_lim) begin
                sat = 1'b1;
                return lo_lim[CW-1:0];
            end
            return v[CW-1:0];
        endfunction

        function void note_point(logic signed [CW-1:0] px, py, pz);
            logic signed [127:0] acc[4];
            logic signed [127:0] pt[3];
            logic signed [127:0] e, v;
            logic signed [CW-1:0] o[3];
            vertex_t r;
            logic sat;
            pt[0] = px;
            pt[1] = py;
            pt[2] = pz;
            sat = 1'b0;
            for (int c = 0; c < 4; c++) begin
                e = mat[3][c];
                acc[c] = e <<< FB;
                for (int k = 0; k < 3; k++) begin
                    e = mat[k][c];
                    acc[c] = acc[c] + pt[k] * e;
                end
            end
            for (int c = 0; c < 3; c++) begin
                if (acc[3] == 0) v = acc[c] >>> FB;
                else v = (acc[c] <<< FB) / acc[3];
                o[c] = clamp(v, sat);
            end
            r.x = o[0];
            r.y = o[1];
            r.z = o[2];
            r.w_zero = (acc[3] == 0);
            r.sat = sat;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [DW-1:0] d, logic [1:0] u);
            vertex_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat data=%h user=%b", d, u));
                return;
            end
            e = pending.pop_front();
            if (d[CW-1:0] !== e.x)
                report($sformatf("out_x %h, expected %h", d[CW-1:0], e.x));
            if (d[2*CW-1:CW] !== e.y)
                report($sformatf("out_y %h, expected %h", d[2*CW-1:CW], e.y));
            if (d[3*CW-1:2*CW] !== e.z)
                report($sformatf("out_z %h, expected %h", d[3*CW-1:2*CW], e.z));
            if (u[0] !== e.w_zero)
                report($sformatf("w_was_zero %b, expected %b", u[0], e.w_zero));
            if (u[1] !== e.sat)
                report($sformatf("saturated %b, expected %b", u[1], e.sat));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [hvt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hvt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0] m_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    vertex_scoreboard sb;
    logic signed [31:0] m[4][4];

    homogeneous_vertex_transform dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    task write_reg(logic [hvt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.load_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task load_matrix();
        write_reg(hvt_pkg::REG_ROW0_COLS01, {m[0][1], m[0][0]});
        write_reg(hvt_pkg::REG_ROW0_COLS23, {m[0][3], m[0][2]});
        write_reg(hvt_pkg::REG_ROW1_COLS01, {m[1][1], m[1][0]});
        write_reg(hvt_pkg::REG_ROW1_COLS23, {m[1][3], m[1][2]});
        write_reg(hvt_pkg::REG_ROW2_COLS01, {m[2][1], m[2][0]});
        write_reg(hvt_pkg::REG_ROW2_COLS23, {m[2][3], m[2][2]});
        write_reg(hvt_pkg::REG_ROW3_COLS01, {m[3][1], m[3][0]});
        write_reg(hvt_pkg::REG_ROW3_COLS23, {m[3][3], m[3][2]});
    endtask

    task drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task send_point(logic signed [CW-1:0] px, py, pz);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_point(px, py, pz);
        @(negedge aclk);
    endtask

    task stop_sending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    function logic signed [31:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000;
            3: return 0;
            default: return $signed($urandom_range(8 * 65536)) - 32'sd4 * ONE;
        endcase
    endfunction

    function logic signed [CW-1:0] rand_coord();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(200 * 65536)) - 32'sd100 * ONE;
    endfunction

    task identity();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? ONE : 0;
    endtask

    initial begin
        sb = new;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at reset are zero: w is zero and nothing moves.
        send_point(ONE, -ONE, 32'sh7fff_ffff);
        stop_sending();
        drain();

        identity();
        load_matrix();
        write_reg(UNUSED_IDX, '1);
        send_point(0, 0, 0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, -1);
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 1);
        send_point(ONE, 2 * ONE, -3 * ONE);
        stop_sending();
        drain();

        // Perspective: w taken from z, so z of zero gives the undivided case.
        identity();
        m[2][3] = ONE;
        m[3][3] = 0;
        load_matrix();
        send_point(ONE, ONE, 0);
        send_point(-5 * ONE, 7 * ONE, 0);
        send_point(4 * ONE, -6 * ONE, 2 * ONE);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 1);
        send_point(ONE, -ONE, -1);
        send_point(32'sh8000_0000, 3, -2 * ONE);
        stop_sending();
        drain();

        // Extreme elements everywhere, alternating between the largest and smallest values.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = ((r + c) % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        load_matrix();
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_point(-1, -1, -1);
        stop_sending();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    m[r][c] = rand_elem();
            if (ph % 3 == 1)
                for (int r = 0; r < 4; r++) m[r][3] = 0;
            load_matrix();
            for (int i = 0; i < 50; i++) begin
                send_point(rand_coord(), rand_coord(), rand_coord());
                if (ph == 2 && i == 25) begin
                    stop_sending();
                    while (sb.pending.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
            end
            stop_sending();
            drain();
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
